// ----- src/linear_probe_hash_set_defines.svh -----
// Assertion macros used by the hash set top level.
`ifndef LINEAR_PROBE_HASH_SET_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define LPHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define LPHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lphs_pkg.sv -----
// Shared types and constants for the linear probing hash set.
package lphs_pkg;

  // Key width and action codes.
  localparam int KEY_W = 31;
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;

  // Slot tag codes.
  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_t;

  // Control states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_INJECT,
    ST_PROBE,
    ST_REPLY
  } state_t;

  // Probe token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    logic             del_valid;
  } token_t;

  // Response of the cell where a probe ends.
  typedef struct packed {
    logic done;
    logic found;
    logic status;
    logic commit;
  } rsp_t;

  // Deferred insert into the first deleted slot of a chain.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } commit_t;

endpackage

// ----- src/lphs_mod.sv -----
// Reduction of a key modulo the slot count by reciprocal multiplication.
module lphs_mod #(
  parameter int SLOTS = 101
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [lphs_pkg::KEY_W-1:0] key,
  output logic                       fin,
  output logic [$clog2(SLOTS)-1:0]   home
);
  import lphs_pkg::*;

  localparam int IW     = $clog2(SLOTS);
  localparam int SHIFT  = KEY_W + IW;
  localparam int PROD_W = 2 * KEY_W + 1;
  // Rounded-up reciprocal of the slot count; it fits in KEY_W + 1 bits and
  // gives the exact quotient for every key of KEY_W bits.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [KEY_W:0]   RECIP   = RECIP_FULL[KEY_W:0];
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(SLOTS);

  logic              run;
  logic              phase;
  logic [KEY_W-1:0]  held_key;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  quot_next;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  qd;
  logic [KEY_W-1:0]  rem;

  assign fin = run && phase;

  // First step: the quotient is the top part of key times the reciprocal.
  assign prod      = PROD_W'(held_key) * PROD_W'(RECIP);
  assign quot_next = KEY_W'(prod >> SHIFT);

  // Second step: the remainder is key minus quotient times the slot count.
  assign qd  = quot * DIVISOR;
  assign rem = held_key - qd;

  // Phase flag: the reduction ends once the quotient has been registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      run   <= 1'b1;
      phase <= 1'b0;
    end else if (run) begin
      phase <= 1'b1;
      if (fin) begin
        run <= 1'b0;
      end
    end
  end

  // Held key, quotient and home slot.
  always_ff @(posedge clk) begin
    if (load) begin
      held_key <= key;
    end
    if (run && !phase) begin
      quot <= quot_next;
    end
    if (fin) begin
      home <= rem[IW-1:0];
    end
  end

endmodule

// ----- src/lphs_cell.sv -----
// One slot of the table, examining the probe token that passes through it.
module lphs_cell #(
  parameter int SLOTS = 101,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lphs_pkg::token_t         tok_in,
  input  logic [$clog2(SLOTS)-1:0] cnt_in,
  input  logic [$clog2(SLOTS)-1:0] del_in,
  input  lphs_pkg::token_t         inj,
  input  logic [$clog2(SLOTS)-1:0] inj_idx,
  input  lphs_pkg::commit_t        cmt,
  input  logic [$clog2(SLOTS)-1:0] cmt_idx,
  output lphs_pkg::token_t         tok_out,
  output logic [$clog2(SLOTS)-1:0] cnt_out,
  output logic [$clog2(SLOTS)-1:0] del_out,
  output lphs_pkg::rsp_t           rsp,
  output logic [$clog2(SLOTS)-1:0] rsp_idx
);
  import lphs_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [IW-1:0] LAST   = IW'(SLOTS - 1);

  tag_t             tag;
  tag_t             tag_next;
  logic [KEY_W-1:0] slot_key;
  logic [KEY_W-1:0] slot_key_next;
  token_t           tin;
  logic [IW-1:0]    cin;
  logic [IW-1:0]    din;
  token_t           tok_next;
  logic [IW-1:0]    cnt_next;
  logic [IW-1:0]    del_next;
  logic             first_del;

  // The injected token starts here when this is its home slot.
  always_comb begin
    if (inj.valid && (inj_idx == MY_IDX)) begin
      tin = inj;
      cin = '0;
      din = '0;
    end else begin
      tin = tok_in;
      cin = cnt_in;
      din = del_in;
    end
  end

  // Examine this slot: stop on empty, on the key, or at the end of a full pass.
  always_comb begin
    tag_next      = tag;
    slot_key_next = slot_key;
    tok_next      = '0;
    cnt_next      = cin + 1'b1;
    del_next      = din;
    rsp           = '0;
    rsp_idx       = '0;
    first_del     = (tag == TAG_DELETED) && !tin.del_valid;
    if (tin.valid) begin
      if (tag == TAG_EMPTY) begin
        rsp.done = 1'b1;
        if (tin.action == ACT_INSERT) begin
          if (tin.del_valid) begin
            rsp.commit = 1'b1;
            rsp_idx    = din;
          end else begin
            tag_next      = TAG_USED;
            slot_key_next = tin.key;
          end
        end
      end else if ((tag == TAG_USED) && (slot_key == tin.key)) begin
        rsp.done  = 1'b1;
        rsp.found = 1'b1;
        if (tin.action == ACT_REMOVE) begin
          tag_next = TAG_DELETED;
        end
      end else if (cin == LAST) begin
        rsp.done = 1'b1;
        if (tin.action == ACT_INSERT) begin
          if (first_del) begin
            tag_next      = TAG_USED;
            slot_key_next = tin.key;
          end else if (tin.del_valid) begin
            rsp.commit = 1'b1;
            rsp_idx    = din;
          end else begin
            rsp.status = 1'b1;
          end
        end
      end else begin
        tok_next = tin;
        if (first_del) begin
          tok_next.del_valid = 1'b1;
          del_next           = MY_IDX;
        end
      end
    end
    // A deferred insert lands here.
    if (cmt.valid && (cmt_idx == MY_IDX)) begin
      tag_next      = TAG_USED;
      slot_key_next = cmt.key;
    end
  end

  // Slot tag and outgoing token valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag     <= TAG_EMPTY;
      tok_out <= '0;
    end else begin
      tag     <= tag_next;
      tok_out <= tok_next;
    end
  end

  // Slot key and token side data.
  always_ff @(posedge clk) begin
    slot_key <= slot_key_next;
    cnt_out  <= cnt_next;
    del_out  <= del_next;
  end

endmodule

// ----- src/linear_probe_hash_set.sv -----
// Top level of the linear probing hash set: control, cell ring and home slot unit.
//
// Open-addressing set of 31-bit keys with linear probing over SLOTS slots. A word
// is taken when start is high and busy is low; its result appears on found and
// status while done is high for one cycle, and the receiver must take it then.
// A word runs through these steps before the next can start, probing 1 up to SLOTS
// slots: the key is reduced to its home slot by multiplying with a rounded-up
// reciprocal of SLOTS, then the probe token moves one cell a cycle around the ring
// of slot cells, then the reply state presents the result and places a deferred
// insert, and the block returns to idle before it takes the next word. All slots
// are empty right after reset.
`include "linear_probe_hash_set_defines.svh"

module linear_probe_hash_set #(
  parameter int SLOTS = 101
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic [lphs_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic                       found,
  output logic                       status
);
  import lphs_pkg::*;

  localparam int IW = $clog2(SLOTS);

  state_t           state;
  state_t           state_next;
  logic [1:0]       act_q;
  logic [KEY_W-1:0] key_q;
  logic             mod_load;
  logic             mod_fin;
  logic [IW-1:0]    home;
  logic             rsp_take;
  logic             cmt_pend;
  logic [IW-1:0]    cmt_idx;
  token_t           inj;
  commit_t          cmt;

  token_t           tok     [SLOTS];
  logic [IW-1:0]    cnt     [SLOTS];
  logic [IW-1:0]    dl      [SLOTS];
  rsp_t             rsp     [SLOTS];
  logic [IW-1:0]    rsp_idx [SLOTS];
  logic [SLOTS-1:0] rsp_done_vec;
  logic [SLOTS-1:0] tok_vld_vec;

  logic             any_done;
  logic             any_found;
  logic             any_status;
  logic             any_commit;
  logic [IW-1:0]    any_idx;

  // Home slot reduction.
  lphs_mod #(
    .SLOTS(SLOTS)
  ) u_mod (
    .clk (clk),
    .rst (rst),
    .load(mod_load),
    .key (key),
    .fin (mod_fin),
    .home(home)
  );

  // Ring of slot cells, each handing the token to the next.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int PREV = (i == 0) ? SLOTS - 1 : i - 1;
    lphs_cell #(
      .SLOTS(SLOTS),
      .IDX  (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[PREV]),
      .cnt_in (cnt[PREV]),
      .del_in (dl[PREV]),
      .inj    (inj),
      .inj_idx(home),
      .cmt    (cmt),
      .cmt_idx(cmt_idx),
      .tok_out(tok[i]),
      .cnt_out(cnt[i]),
      .del_out(dl[i]),
      .rsp    (rsp[i]),
      .rsp_idx(rsp_idx[i])
    );
    assign rsp_done_vec[i] = rsp[i].done;
    assign tok_vld_vec[i]  = tok[i].valid;
  end

  // Gather the response of the one cell where the probe ended.
  always_comb begin
    any_done   = 1'b0;
    any_found  = 1'b0;
    any_status = 1'b0;
    any_commit = 1'b0;
    any_idx    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_done   = any_done | rsp[i].done;
      any_found  = any_found | rsp[i].found;
      any_status = any_status | rsp[i].status;
      any_commit = any_commit | rsp[i].commit;
      any_idx    = any_idx | rsp_idx[i];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_HASH;
      ST_HASH:   if (mod_fin) state_next = ST_INJECT;
      ST_INJECT: state_next = any_done ? ST_REPLY : ST_PROBE;
      ST_PROBE:  if (any_done) state_next = ST_REPLY;
      ST_REPLY:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy          = (state != ST_IDLE);
    done          = (state == ST_REPLY);
    mod_load      = (state == ST_IDLE) && start;
    rsp_take      = ((state == ST_INJECT) || (state == ST_PROBE)) && any_done;
    inj.valid     = (state == ST_INJECT);
    inj.action    = act_q;
    inj.key       = key_q;
    inj.del_valid = 1'b0;
    cmt.valid     = (state == ST_REPLY) && cmt_pend;
    cmt.key       = key_q;
  end

  // State and pending commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cmt_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_take) begin
        cmt_pend <= any_commit;
      end
    end
  end

  // Accepted word and registered result.
  always_ff @(posedge clk) begin
    if (mod_load) begin
      act_q <= action;
      key_q <= key;
    end
    if (rsp_take) begin
      found   <= any_found;
      status  <= any_status;
      cmt_idx <= any_idx;
    end
  end

  // At most one cell holds the probe token and at most one ends it.
  `LPHS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vld_vec), "More than one probe token")
  `LPHS_ASSERT_NOW(a_one_end, 1'b1, $onehot0(rsp_done_vec), "More than one probe end")
  // An accepted word keeps the block busy in the next cycle.
  `LPHS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted word did not raise busy")
  // A deferred write only serves an insert of a new key that was not refused.
  `LPHS_ASSERT_NOW(a_commit_insert, cmt.valid,
                   !found && !status && (act_q == ACT_INSERT), "Commit without a new insert")

endmodule
